FILE: hw/rtl/pgi_pkg.sv
// Shared constants, types and command structures of the palette gradient interpolator.
package pgi_pkg;

  localparam int PALETTE_DEPTH = 64;
  localparam int T_FRAC_BITS   = 16;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

  localparam int COLOUR_W  = 24;
  localparam int CHAN_W    = 8;
  localparam int LANES     = 3;
  localparam int IDX_W     = 7;
  localparam int FRAC_W    = 17;
  localparam int CTRL_W    = 16;
  localparam int COUNT_W   = 7;
  localparam int ACTION_W  = 2;

  localparam int T_W    = T_FRAC_BITS + 1;
  localparam int WGT_W  = T_W + 1;
  localparam int LA_W   = WGT_W + 1;
  localparam int LB_W   = CTRL_W + 1;
  localparam int PROD_W = LA_W + LB_W;
  localparam int ACC_W  = PROD_W + 2;

  localparam int unsigned T_ONE = 32'd1 << T_FRAC_BITS;
  localparam int BEZ_SH = T_FRAC_BITS + 4;
  localparam logic [ACC_W-1:0] BEZ_RND = (ACC_W'(1) << BEZ_SH) - ACC_W'(1);

  localparam int IA_LSB      = 0;
  localparam int IB_LSB      = IA_LSB + IDX_W;
  localparam int FT_LSB      = IB_LSB + IDX_W;
  localparam int CF_LSB      = FT_LSB + FRAC_W;
  localparam int CS_LSB      = CF_LSB + CTRL_W;
  localparam int EC_LSB      = CS_LSB + CTRL_W;
  localparam int IN_FIELDS_W = EC_LSB + COLOUR_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = COLOUR_W;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_COLOUR = 2'd1;
  localparam logic [COLOUR_W-1:0]  DEFAULT_COLOUR_RST = 24'hFFFFFF;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE, ACT_LOOKUP, ACT_LERP, ACT_BEZIER
  } action_t;

  typedef enum logic [2:0] {
    WOP_NONE, WOP_UU, WOP_TT, WOP_W0, WOP_W1, WOP_W2, WOP_W3
  } wop_t;

  typedef enum logic [2:0] {
    TERM_LERP, TERM_W0C1, TERM_W1A, TERM_W2B, TERM_W3C2
  } term_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_CLEAR, ACC_LOAD, ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    RES_DEFAULT, RES_LOOKUP, RES_LERP, RES_BEZIER
  } res_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_B, ST_C2, ST_L_MUL, ST_L_ACC,
    ST_W_UU, ST_W_TT, ST_W_0, ST_W_1, ST_W_2, ST_W_3,
    ST_B_0, ST_B_1, ST_B_2, ST_B_3, ST_B_ACC, ST_FIN
  } state_t;

  typedef struct packed {
    logic     cap;
    logic     wr;
    logic     rd_sel_b;
    logic     ld_c1;
    logic     ld_c2;
    wop_t     wop;
    term_t    term;
    acc_op_t  acc_op;
    res_sel_t res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    invalid;
  } sts_t;

endpackage

FILE: hw/rtl/pgi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pgi_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/pgi_datapath.sv
// Datapath: configuration registers, palette memory, weight multiplier and three channel lanes.
module pgi_datapath import pgi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [ACTION_W-1:0]   in_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic [COLOUR_W-1:0]   colour_out,
  output logic                  used_default
);

  logic [COUNT_W-1:0]  palette_count_r;
  logic [COLOUR_W-1:0] default_colour_r;

  logic [IDX_W-1:0]    in_index_a;
  logic [IDX_W-1:0]    in_index_b;
  logic [FRAC_W-1:0]   in_frac_t;
  logic [CTRL_W-1:0]   in_ctrl_first;
  logic [CTRL_W-1:0]   in_ctrl_second;
  logic [COLOUR_W-1:0] in_entry_colour;
  logic                ok_a;
  logic                ok_b;

  logic [IDX_W-1:0]    index_b_r;
  logic [T_W-1:0]      t_r;
  logic [T_W-1:0]      t_sat;
  logic [T_W-1:0]      u_w;
  logic [CTRL_W-1:0]   ctrl_a_r;
  logic [CTRL_W-1:0]   ctrl_b_r;

  logic                ram_we;
  logic [PAL_AW-1:0]   ram_raddr;
  logic [COLOUR_W-1:0] ram_rdata;
  logic [COLOUR_W-1:0] c1_r;
  logic [COLOUR_W-1:0] c2_r;

  logic [T_W-1:0]      wa;
  logic [T_W-1:0]      wb;
  logic [2*T_W-1:0]    wprod;
  logic [T_W-1:0]      wq;
  logic [WGT_W-1:0]    w3x;
  logic [T_W-1:0]      uu_r;
  logic [T_W-1:0]      tt_r;
  logic [T_W-1:0]      w0_r;
  logic [WGT_W-1:0]    w1_r;
  logic [WGT_W-1:0]    w2_r;
  logic [T_W-1:0]      w3_r;

  logic [CHAN_W:0]            diff   [LANES];
  logic signed [LA_W-1:0]     lane_a [LANES];
  logic signed [LB_W-1:0]     lane_b [LANES];
  logic signed [PROD_W-1:0]   prod_r [LANES];
  logic signed [ACC_W-1:0]    acc_r  [LANES];
  logic [ACC_W-1:0]           rnd    [LANES];
  logic [COLOUR_W-1:0]        lerp_colour;
  logic [COLOUR_W-1:0]        bez_colour;
  logic [COLOUR_W-1:0]        colour_r;
  logic                       used_r;

  assign in_index_a      = in_tdata[IA_LSB +: IDX_W];
  assign in_index_b      = in_tdata[IB_LSB +: IDX_W];
  assign in_frac_t       = in_tdata[FT_LSB +: FRAC_W];
  assign in_ctrl_first   = in_tdata[CF_LSB +: CTRL_W];
  assign in_ctrl_second  = in_tdata[CS_LSB +: CTRL_W];
  assign in_entry_colour = in_tdata[EC_LSB +: COLOUR_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_count_r  <= '0;
      default_colour_r <= DEFAULT_COLOUR_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_PALETTE_COUNT) begin
        palette_count_r <= cfg_data[COUNT_W-1:0];
      end else if (cfg_index == REG_DEFAULT_COLOUR) begin
        default_colour_r <= cfg_data[COLOUR_W-1:0];
      end
    end
  end

  assign ok_a = (in_index_a < palette_count_r) && (32'(in_index_a) < PALETTE_DEPTH);
  assign ok_b = (in_index_b < palette_count_r) && (32'(in_index_b) < PALETTE_DEPTH);
  assign sts.action  = action_t'(in_tuser);
  assign sts.invalid = !ok_a || ((action_t'(in_tuser) != ACT_LOOKUP) && !ok_b);

  assign t_sat = (32'(in_frac_t) > T_ONE) ? T_W'(T_ONE) : T_W'(in_frac_t);
  assign u_w   = T_W'(T_ONE) - t_r;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      index_b_r <= in_index_b;
      t_r       <= t_sat;
      ctrl_a_r  <= in_ctrl_first;
      ctrl_b_r  <= in_ctrl_second;
    end
  end

  assign ram_we    = cmd.wr && (32'(in_index_a) < PALETTE_DEPTH);
  assign ram_raddr = cmd.rd_sel_b ? PAL_AW'(index_b_r) : PAL_AW'(in_index_a);

  pgi_ram #(
    .WIDTH (COLOUR_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (PAL_AW'(in_index_a)),
    .wdata (in_entry_colour),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.ld_c1) begin
      c1_r <= ram_rdata;
    end
    if (cmd.ld_c2) begin
      c2_r <= ram_rdata;
    end
  end

  always_comb begin
    unique case (cmd.wop)
      WOP_UU:  begin wa = u_w;  wb = u_w; end
      WOP_TT:  begin wa = t_r;  wb = t_r; end
      WOP_W0:  begin wa = uu_r; wb = u_w; end
      WOP_W1:  begin wa = uu_r; wb = t_r; end
      WOP_W2:  begin wa = tt_r; wb = u_w; end
      WOP_W3:  begin wa = tt_r; wb = t_r; end
      default: begin wa = '0;   wb = '0;  end
    endcase
  end

  assign wprod = wa * wb;
  assign wq    = wprod[T_FRAC_BITS +: T_W];
  assign w3x   = {wq, 1'b0} + WGT_W'(wq);

  always_ff @(posedge clk) begin
    unique case (cmd.wop)
      WOP_UU:  uu_r <= wq;
      WOP_TT:  tt_r <= wq;
      WOP_W0:  w0_r <= wq;
      WOP_W1:  w1_r <= w3x;
      WOP_W2:  w2_r <= w3x;
      WOP_W3:  w3_r <= wq;
      default: ;
    endcase
  end

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      diff[k] = {1'b0, c2_r[CHAN_W*k +: CHAN_W]} - {1'b0, c1_r[CHAN_W*k +: CHAN_W]};
      unique case (cmd.term)
        TERM_LERP: begin
          lane_a[k] = $signed(LA_W'(t_r));
          lane_b[k] = $signed({{(LB_W-CHAN_W-1){diff[k][CHAN_W]}}, diff[k]});
        end
        TERM_W0C1: begin
          lane_a[k] = $signed(LA_W'(w0_r));
          lane_b[k] = $signed({{(LB_W-CHAN_W-4){1'b0}}, c1_r[CHAN_W*k +: CHAN_W], 4'b0});
        end
        TERM_W1A: begin
          lane_a[k] = $signed(LA_W'(w1_r));
          lane_b[k] = $signed({ctrl_a_r[CTRL_W-1], ctrl_a_r});
        end
        TERM_W2B: begin
          lane_a[k] = $signed(LA_W'(w2_r));
          lane_b[k] = $signed({ctrl_b_r[CTRL_W-1], ctrl_b_r});
        end
        TERM_W3C2: begin
          lane_a[k] = $signed(LA_W'(w3_r));
          lane_b[k] = $signed({{(LB_W-CHAN_W-4){1'b0}}, c2_r[CHAN_W*k +: CHAN_W], 4'b0});
        end
        default: begin
          lane_a[k] = '0;
          lane_b[k] = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < LANES; k++) begin
      prod_r[k] <= lane_a[k] * lane_b[k];
      unique case (cmd.acc_op)
        ACC_CLEAR: acc_r[k] <= '0;
        ACC_LOAD:  acc_r[k] <= $signed(ACC_W'(c1_r[CHAN_W*k +: CHAN_W]) << T_FRAC_BITS);
        ACC_ADD:   acc_r[k] <= acc_r[k] +
                               $signed({{(ACC_W-PROD_W){prod_r[k][PROD_W-1]}}, prod_r[k]});
        default:   ;
      endcase
    end
  end

  // Bezier channels divide by 16 * one, truncating toward zero, so negative sums are
  // biased up before the shift.
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      rnd[k] = acc_r[k] + (acc_r[k][ACC_W-1] ? BEZ_RND : '0);
      lerp_colour[CHAN_W*k +: CHAN_W] = acc_r[k][T_FRAC_BITS +: CHAN_W];
      bez_colour[CHAN_W*k +: CHAN_W]  = rnd[k][BEZ_SH +: CHAN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (cmd.res_sel)
        RES_DEFAULT: begin colour_r <= default_colour_r; used_r <= 1'b1; end
        RES_LOOKUP:  begin colour_r <= c1_r;             used_r <= 1'b0; end
        RES_LERP:    begin colour_r <= lerp_colour;      used_r <= 1'b0; end
        RES_BEZIER:  begin colour_r <= bez_colour;       used_r <= 1'b0; end
        default:     begin colour_r <= default_colour_r; used_r <= 1'b1; end
      endcase
    end
  end

  assign colour_out   = colour_r;
  assign used_default = used_r;

endmodule

FILE: hw/rtl/pgi_ctrl.sv
// Controller state machine that sequences reads, weight products and channel terms.
module pgi_ctrl import pgi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t   state_r, state_nxt;
  action_t  act_r, act_nxt;
  res_sel_t res_sel_r, res_sel_nxt;
  logic     out_valid_r, out_valid_nxt;
  logic     in_xfer;

  assign in_xfer = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      act_r       <= ACT_WRITE;
      res_sel_r   <= RES_DEFAULT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      act_r       <= act_nxt;
      res_sel_r   <= res_sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    act_nxt      = act_r;
    res_sel_nxt  = res_sel_r;
    in_tready    = 1'b0;
    cmd.cap      = 1'b0;
    cmd.wr       = 1'b0;
    cmd.rd_sel_b = 1'b0;
    cmd.ld_c1    = 1'b0;
    cmd.ld_c2    = 1'b0;
    cmd.wop      = WOP_NONE;
    cmd.term     = TERM_LERP;
    cmd.acc_op   = ACC_HOLD;
    cmd.res_sel  = res_sel_r;
    cmd.out_load = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.cap = 1'b1;
          act_nxt = sts.action;
          if (sts.action == ACT_WRITE) begin
            cmd.wr = 1'b1;
          end else if (sts.invalid) begin
            res_sel_nxt = RES_DEFAULT;
            state_nxt   = ST_FIN;
          end else begin
            state_nxt = ST_RD_B;
          end
        end
      end
      ST_RD_B: begin
        cmd.ld_c1    = 1'b1;
        cmd.rd_sel_b = 1'b1;
        if (act_r == ACT_LOOKUP) begin
          res_sel_nxt = RES_LOOKUP;
          state_nxt   = ST_FIN;
        end else begin
          state_nxt = ST_C2;
        end
      end
      ST_C2: begin
        cmd.ld_c2 = 1'b1;
        state_nxt = (act_r == ACT_LERP) ? ST_L_MUL : ST_W_UU;
      end
      ST_L_MUL: begin
        cmd.term   = TERM_LERP;
        cmd.acc_op = ACC_LOAD;
        state_nxt  = ST_L_ACC;
      end
      ST_L_ACC: begin
        cmd.acc_op  = ACC_ADD;
        res_sel_nxt = RES_LERP;
        state_nxt   = ST_FIN;
      end
      ST_W_UU: begin cmd.wop = WOP_UU; state_nxt = ST_W_TT; end
      ST_W_TT: begin cmd.wop = WOP_TT; state_nxt = ST_W_0;  end
      ST_W_0:  begin cmd.wop = WOP_W0; state_nxt = ST_W_1;  end
      ST_W_1:  begin cmd.wop = WOP_W1; state_nxt = ST_W_2;  end
      ST_W_2:  begin cmd.wop = WOP_W2; state_nxt = ST_W_3;  end
      ST_W_3:  begin cmd.wop = WOP_W3; state_nxt = ST_B_0;  end
      ST_B_0: begin
        cmd.term   = TERM_W0C1;
        cmd.acc_op = ACC_CLEAR;
        state_nxt  = ST_B_1;
      end
      ST_B_1: begin
        cmd.term   = TERM_W1A;
        cmd.acc_op = ACC_ADD;
        state_nxt  = ST_B_2;
      end
      ST_B_2: begin
        cmd.term   = TERM_W2B;
        cmd.acc_op = ACC_ADD;
        state_nxt  = ST_B_3;
      end
      ST_B_3: begin
        cmd.term   = TERM_W3C2;
        cmd.acc_op = ACC_ADD;
        state_nxt  = ST_B_ACC;
      end
      ST_B_ACC: begin
        cmd.acc_op  = ACC_ADD;
        res_sel_nxt = RES_BEZIER;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("Result register loaded while a result was still waiting.");

  a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && sts.action == ACT_WRITE) |=> in_tready)
    else $error("A write transfer did not leave the block ready.");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && sts.action != ACT_WRITE) |=> !in_tready)
    else $error("A query transfer did not occupy the block.");

  a_c2_after_c1: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_c2 |-> $past(cmd.ld_c1))
    else $error("Second palette entry latched without the first one before it.");

endmodule

FILE: hw/rtl/palette_gradient_interpolator_core.sv
// Top level of the palette gradient interpolator: controller, datapath and ports.
//
// The input channel carries one item per transfer. A write item (tuser 0) stores
// entry_colour at index_a and gives no result; a lookup (1), linear blend (2) or
// cubic Bezier blend (3) gives exactly one result on the output channel, where
// tdata holds the packed colour and tuser flags that the default colour was used.
// The configuration channel writes palette_count (index 0) and default_colour
// (index 1); it is always ready and should only be used while the block is idle.
// Items are handled one at a time. A write leaves the block ready in the next
// cycle; a query with an invalid index goes straight to the final state, a lookup
// reads its entry, a linear blend reads both entries and adds a lane product, and
// a Bezier blend reads both, forms six products on the single weight multiplier,
// then four lane products per channel. Reads use the one read port of the palette
// memory. The result is loaded into the output register on the return to idle; it
// can wait there while the next item is taken in; if the receiver stalls longer,
// the block holds its next result and stops taking items until the output frees.
// Reset clears the control state, sets palette_count to zero and default_colour to
// white; palette entries are undefined until written.
module palette_gradient_interpolator_core import pgi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // index_a, index_b, frac_t, ctrl_first, ctrl_second, entry_colour, zero pad
  input  logic [IN_TDATA_W-1:0] in_tdata,
  // action
  input  logic [ACTION_W-1:0]   in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // colour_out
  output logic [COLOUR_W-1:0]   out_tdata,
  // used_default
  output logic                  out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  pgi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pgi_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sts          (sts),
    .colour_out   (out_tdata),
    .used_default (out_tuser)
  );

endmodule

FILE: tb/sv/tb_palette_gradient_interpolator_core.sv
// Self-checking testbench for the palette gradient interpolator core, with a scoreboard and stream drivers.
`timescale 1ns / 100ps

module tb_palette_gradient_interpolator_core;
  import pgi_pkg::*;

  localparam longint TONE = longint'(T_ONE);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES = 7;

  typedef struct {
    logic [COLOUR_W-1:0] colour;
    logic                used_default;
  } shade_t;

  class palette_scoreboard;
    logic [COLOUR_W-1:0] palette [PALETTE_DEPTH];
    int unsigned         count;
    logic [COLOUR_W-1:0] fallback;
    shade_t              pending_shades [$];
    int unsigned         mismatches;
    int unsigned         checked;
    int unsigned         reg_writes;
    int unsigned         action_seen [4];

    function new();
      foreach (palette[i]) palette[i] = '0;
      count = 0;
      fallback = DEFAULT_COLOUR_RST;
      mismatches = 0;
      checked = 0;
      reg_writes = 0;
      foreach (action_seen[i]) action_seen[i] = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      if (idx == REG_PALETTE_COUNT) count = 32'(data[COUNT_W-1:0]);
      else if (idx == REG_DEFAULT_COLOUR) fallback = data[COLOUR_W-1:0];
    endfunction

    function bit in_range(logic [IDX_W-1:0] idx);
      return idx < count && idx < PALETTE_DEPTH;
    endfunction

    function void note_item(action_t act, logic [IDX_W-1:0] ia, logic [IDX_W-1:0] ib,
                            logic [FRAC_W-1:0] ft, logic [CTRL_W-1:0] cf,
                            logic [CTRL_W-1:0] cs, logic [COLOUR_W-1:0] ec);
      shade_t              shade;
      logic [COLOUR_W-1:0] ca, cb;
      longint              t, u, uu, tt, w0, w1, w2, w3, a, b, c1, c2, lane;
      action_seen[act]++;
      if (act == ACT_WRITE) begin
        if (ia < PALETTE_DEPTH) palette[ia[PAL_AW-1:0]] = ec;
        return;
      end
      t = (ft > T_ONE) ? TONE : longint'(ft);
      shade.colour = '0;
      shade.used_default = 1'b0;
      if (!in_range(ia) || (act != ACT_LOOKUP && !in_range(ib))) begin
        shade.colour = fallback;
        shade.used_default = 1'b1;
      end else if (act == ACT_LOOKUP) begin
        shade.colour = palette[ia[PAL_AW-1:0]];
      end else begin
        ca = palette[ia[PAL_AW-1:0]];
        cb = palette[ib[PAL_AW-1:0]];
        a = longint'($signed(cf));
        b = longint'($signed(cs));
        u = TONE - t;
        uu = (u * u) >> T_FRAC_BITS;
        tt = (t * t) >> T_FRAC_BITS;
        w0 = (uu * u) >> T_FRAC_BITS;
        w1 = 3 * ((uu * t) >> T_FRAC_BITS);
        w2 = 3 * ((tt * u) >> T_FRAC_BITS);
        w3 = (tt * t) >> T_FRAC_BITS;
        for (int k = 0; k < LANES; k++) begin
          c1 = longint'(ca[CHAN_W*k +: CHAN_W]);
          c2 = longint'(cb[CHAN_W*k +: CHAN_W]);
          if (act == ACT_LERP) begin
            lane = c1 * TONE + t * (c2 - c1);
            if (lane < 0) lane = 0;
            lane = lane >>> T_FRAC_BITS;
          end else begin
            lane = (16 * w0 * c1 + w1 * a + w2 * b + 16 * w3 * c2) / (16 * TONE);
          end
          shade.colour[CHAN_W*k +: CHAN_W] = lane[CHAN_W-1:0];
        end
      end
      pending_shades.push_back(shade);
    endfunction

    function void check_result(logic [COLOUR_W-1:0] colour, logic used_default);
      shade_t shade;
      checked++;
      if (pending_shades.size() == 0) begin
        $error("colour_out: no result expected, actual %06h used_default %0b",
               colour, used_default);
        mismatches++;
        return;
      end
      shade = pending_shades.pop_front();
      if (colour !== shade.colour) begin
        $error("colour_out: expected %06h, actual %06h", shade.colour, colour);
        mismatches++;
      end
      if (used_default !== shade.used_default) begin
        $error("used_default: expected %0b, actual %0b", shade.used_default, used_default);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic [ACTION_W-1:0]   in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [COLOUR_W-1:0]   out_tdata;
  logic                  out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  palette_scoreboard sb = new();
  int unsigned in_idle_pct = 16;
  int unsigned out_idle_pct = 16;
  int unsigned hold_cycles = 0;

  palette_gradient_interpolator_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_palette_gradient_interpolator_core: errors");
    $finish;
  end

  // Results are checked before new queries are noted, so one edge never reorders the queue.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if (in_tvalid && in_tready)
        sb.note_item(action_t'(in_tuser), in_tdata[IA_LSB +: IDX_W], in_tdata[IB_LSB +: IDX_W],
                     in_tdata[FT_LSB +: FRAC_W], in_tdata[CF_LSB +: CTRL_W],
                     in_tdata[CS_LSB +: CTRL_W], in_tdata[EC_LSB +: COLOUR_W]);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  initial begin
    forever begin
      if (hold_cycles != 0) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        out_tready <= ($urandom_range(99) >= out_idle_pct);
        @(posedge clk);
      end
    end
  end

  task automatic send_item(action_t act, logic [IDX_W-1:0] ia, logic [IDX_W-1:0] ib,
                           logic [FRAC_W-1:0] ft, logic [CTRL_W-1:0] cf,
                           logic [CTRL_W-1:0] cs, logic [COLOUR_W-1:0] ec);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= IN_TDATA_W'({ec, cs, cf, ft, ib, ia});
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Writes give no result, so the block may still be busy once the queue is empty.
  task automatic settle();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (sb.pending_shades.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [IDX_W-1:0] pick_index(int unsigned live);
    if (live != 0 && $urandom_range(99) < 85)
      return IDX_W'($urandom_range((live > PALETTE_DEPTH ? PALETTE_DEPTH : live) - 1));
    return IDX_W'($urandom_range((1 << IDX_W) - 1));
  endfunction

  function automatic logic [CTRL_W-1:0] pick_ctrl();
    case ($urandom_range(9))
      0:       return ($urandom_range(1) != 0) ? 16'h8000 : 16'h7FFF;
      1, 2, 3: return CTRL_W'($urandom_range(16'hFFFF));
      default: return CTRL_W'($urandom_range(16 * 255));
    endcase
  endfunction

  task automatic run_random(int unsigned n);
    action_t           act;
    logic [IDX_W-1:0]  ia, ib;
    logic [FRAC_W-1:0] ft;
    int unsigned       roll, sent;
    sent = 0;
    while (sent < n) begin
      roll = $urandom_range(99);
      if (roll < 20) act = ACT_WRITE;
      else if (roll < 40) act = ACT_LOOKUP;
      else if (roll < 70) act = ACT_LERP;
      else act = ACT_BEZIER;
      if (act == ACT_WRITE)
        ia = ($urandom_range(9) == 0) ? IDX_W'($urandom_range(127))
                                      : IDX_W'($urandom_range(PALETTE_DEPTH - 1));
      else
        ia = pick_index(sb.count);
      ib = pick_index(sb.count);
      case ($urandom_range(9))
        0: ft = FRAC_W'($urandom_range((1 << FRAC_W) - 1));
        1: begin
          case ($urandom_range(4))
            0:       ft = '0;
            1:       ft = FRAC_W'(1);
            2:       ft = FRAC_W'(T_ONE - 1);
            3:       ft = FRAC_W'(T_ONE);
            default: ft = '1;
          endcase
        end
        default: ft = FRAC_W'($urandom_range(T_ONE));
      endcase
      send_item(act, ia, ib, ft, pick_ctrl(), pick_ctrl(),
                COLOUR_W'($urandom_range(24'hFFFFFF)));
      if (!(act == ACT_WRITE && ia >= PALETTE_DEPTH)) sent++;
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= ACT_WRITE;
    cfg_valid <= 1'b0;
    cfg_index <= REG_PALETTE_COUNT;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With no palette loaded every query falls back to the reset default colour.
    send_item(ACT_LOOKUP, 0, 0, 0, 0, 0, 0);
    send_item(ACT_LERP, 0, 1, FRAC_W'(T_ONE / 2), 0, 0, 0);
    send_item(ACT_BEZIER, 127, 127, FRAC_W'(T_ONE), 16'h7FFF, 16'h8000, 0);
    send_item(ACT_WRITE, 64, 0, 0, 0, 0, 24'h123456);
    send_item(ACT_WRITE, 127, 0, 0, 0, 0, 24'hFEDCBA);

    send_item(ACT_WRITE, 0, 0, 0, 0, 0, 24'h000000);
    send_item(ACT_WRITE, 1, 0, 0, 0, 0, 24'hFFFFFF);
    for (int i = 2; i < PALETTE_DEPTH; i++)
      send_item(ACT_WRITE, IDX_W'(i), IDX_W'($urandom_range(127)), 0, 0, 0,
                COLOUR_W'($urandom_range(24'hFFFFFF)));
    settle();
    write_cfg(REG_PALETTE_COUNT, CFG_DATA_W'(PALETTE_DEPTH));
    write_cfg(REG_DEFAULT_COLOUR, CFG_DATA_W'($urandom_range(24'hFFFFFF)));

    send_item(ACT_LOOKUP, 0, 127, 0, 0, 0, 0);
    send_item(ACT_LOOKUP, IDX_W'(PALETTE_DEPTH - 1), 0, '1, 16'hFFFF, 16'hFFFF, 0);
    send_item(ACT_LOOKUP, IDX_W'(PALETTE_DEPTH), 0, 0, 0, 0, 0);
    send_item(ACT_LERP, 0, 1, 0, 0, 0, 0);
    send_item(ACT_LERP, 0, 1, FRAC_W'(T_ONE), 0, 0, 0);
    send_item(ACT_LERP, 1, 0, FRAC_W'(T_ONE / 2), 0, 0, 0);
    send_item(ACT_LERP, 0, 1, '1, 0, 0, 0);
    send_item(ACT_LERP, 5, 100, FRAC_W'(T_ONE / 3), 0, 0, 0);
    send_item(ACT_BEZIER, 0, 1, 0, 16'h7FFF, 16'h8000, 0);
    send_item(ACT_BEZIER, 0, 1, FRAC_W'(T_ONE), 16'h7FFF, 16'h8000, 0);
    send_item(ACT_BEZIER, 0, 0, FRAC_W'(T_ONE / 2), 16'h8000, 16'h8000, 0);
    send_item(ACT_BEZIER, 1, 1, FRAC_W'(T_ONE / 2), 16'h7FFF, 16'h7FFF, 0);
    send_item(ACT_BEZIER, 7, 9, 1, 16'hFFF0, 16'h0100, 0);
    send_item(ACT_BEZIER, 9, 7, FRAC_W'(T_ONE - 1), 16'h0100, 16'hFFF0, 0);
    send_item(ACT_BEZIER, 3, 60, '1, 16'h0FF0, 16'h0000, 0);
    send_item(ACT_BEZIER, 127, 3, FRAC_W'(T_ONE / 4), 0, 0, 0);
    send_item(ACT_WRITE, 10, 0, 0, 0, 0, 24'hA5C30F);
    send_item(ACT_LOOKUP, 10, 0, 0, 0, 0, 0);
    send_item(ACT_WRITE, 100, 0, 0, 0, 0, 24'h5A3CF0);
    send_item(ACT_LOOKUP, 100, 0, 0, 0, 0, 0);
    settle();
    write_cfg(REG_PALETTE_COUNT, 1);
    send_item(ACT_LOOKUP, 0, 0, 0, 0, 0, 0);
    send_item(ACT_LOOKUP, 1, 0, 0, 0, 0, 0);
    send_item(ACT_LERP, 0, 0, FRAC_W'(T_ONE / 2), 0, 0, 0);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: write_cfg(REG_PALETTE_COUNT, CFG_DATA_W'(PALETTE_DEPTH));
        1: write_cfg(REG_PALETTE_COUNT, 1);
        2: write_cfg(REG_PALETTE_COUNT, 127);
        3: write_cfg(REG_PALETTE_COUNT, 33);
        4: write_cfg(REG_PALETTE_COUNT, 0);
        5: write_cfg(REG_PALETTE_COUNT, 2);
        default: write_cfg(REG_PALETTE_COUNT, CFG_DATA_W'(PALETTE_DEPTH));
      endcase
      if (p == 1) write_cfg(REG_DEFAULT_COLOUR, 24'h000000);
      else if (p == 2) write_cfg(REG_DEFAULT_COLOUR, 24'hFFFFFF);
      else write_cfg(REG_DEFAULT_COLOUR, CFG_DATA_W'($urandom_range(24'hFFFFFF)));
      if (p == 1) write_cfg(REG_SPARE_A, CFG_DATA_W'($urandom_range(24'hFFFFFF)));
      if (p == 5) write_cfg(REG_SPARE_B, CFG_DATA_W'($urandom_range(24'hFFFFFF)));
      in_idle_pct  = (p == 3) ? 0 : 16;
      out_idle_pct = (p == 3) ? 0 : 16;
      if (p == 2) hold_cycles = HOLD_CYCLES;
      run_random(170);
      if (p == 6) begin
        settle();
        run_random(30);
      end
      settle();
    end

    if (sb.pending_shades.size() != 0) begin
      $error("colour_out: %0d expected results never arrived", sb.pending_shades.size());
      sb.mismatches++;
    end
    $display("Covered %0d writes, %0d lookups, %0d linear and %0d Bezier blends.",
             sb.action_seen[ACT_WRITE], sb.action_seen[ACT_LOOKUP],
             sb.action_seen[ACT_LERP], sb.action_seen[ACT_BEZIER]);
    $display("Checked %0d results across %0d register writes, with %0d field mismatches.",
             sb.checked, sb.reg_writes, sb.mismatches);
    if (sb.mismatches == 0)
      $display("tb_palette_gradient_interpolator_core: clean");
    else
      $display("tb_palette_gradient_interpolator_core: errors");
    $finish;
  end

endmodule
